@@ hdl/odq_pkg.sv @@
// Package for the once-only event dedup queue.
// Holds request codes, the fixed field widths and the cell control type; no dependencies.
package odq_pkg;

    localparam int ID_W    = 6;
    localparam int MODE_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [MODE_W-1:0] MODE_FIRE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TAKE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Per-cycle control handed from the sequencer to one queue cell.
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

@@ hdl/odq_if.sv @@
// Valid/ready channel interfaces for the request and the response.
// Depends on odq_pkg for the field widths.
interface odq_req_if;
    logic                        valid;
    logic                        ready;
    logic [odq_pkg::MODE_W-1:0]  mode;
    logic [odq_pkg::ID_W-1:0]    event_id;
    logic                        use_once_flags;

    modport source (output valid, mode, event_id, use_once_flags, input ready);
    modport sink   (input valid, mode, event_id, use_once_flags, output ready);
endinterface

interface odq_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        accepted;
    logic                        dropped_full;
    logic                        popped_valid;
    logic [odq_pkg::ID_W-1:0]    popped_id;
    logic                        pending;
    logic [odq_pkg::COUNT_W-1:0] pending_count;

    modport source (output valid, accepted, dropped_full, popped_valid, popped_id,
                    pending, pending_count, input ready);
    modport sink   (input valid, accepted, dropped_full, popped_valid, popped_id,
                    pending, pending_count, output ready);
endinterface

@@ hdl/odq_cell.sv @@
// One queue cell: holds an id, shifts from its neighbor on a pop,
// loads a new id on a push, and compares its id against the request.
// Depends on odq_pkg.
module odq_cell (
    input  logic                     i_clk,
    input  odq_pkg::t_cell_ctl       i_ctl,
    input  logic [odq_pkg::ID_W-1:0] i_nb_data,
    input  logic [odq_pkg::ID_W-1:0] i_load_data,
    input  logic                     i_occupied,
    input  logic [odq_pkg::ID_W-1:0] i_cmp_id,
    output logic [odq_pkg::ID_W-1:0] o_data,
    output logic                     o_match
);
    logic [odq_pkg::ID_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_data <= i_nb_data;
        end else if (i_ctl.load) begin
            r_data <= i_load_data;
        end
    end

    assign o_data  = r_data;
    assign o_match = i_occupied && (r_data == i_cmp_id);
endmodule

@@ hdl/odq_flag_map.sv @@
// Once-only flag map: one flip-flop per event id, cleared by reset.
// Depends on odq_pkg.
module odq_flag_map #(
    parameter int ID_LIMIT = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [$clog2(ID_LIMIT)-1:0]  i_idx,
    input  logic                         i_set,
    output logic                         o_flag
);
    logic [ID_LIMIT-1:0] r_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_set) begin
            r_flags[i_idx] <= 1'b1;
        end
    end

    assign o_flag = r_flags[i_idx];
endmodule

@@ hdl/once_only_event_dedup_queue.sv @@
// Once-only event dedup queue: flag map plus a shifting FIFO of cells.
// A request is captured, then executed around the parallel cell compare, and its
// response is registered; no new request is taken until the execute step is done.
// A new request is taken while the previous response still waits in its register.
// Reset (synchronous, active low) clears the flag map, the count and all control.
module once_only_event_dedup_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_LIMIT    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    odq_req_if.sink     i_req,
    odq_rsp_if.source   o_rsp
);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(ID_LIMIT);

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state                     r_state;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;

    // Captured request. Payload only, so it carries no reset.
    logic [odq_pkg::MODE_W-1:0] r_mode;
    logic [odq_pkg::ID_W-1:0]   r_id;
    logic                       r_use;

    // Registered response.
    logic                       r_rsp_valid;
    logic                       r_accepted;
    logic                       r_dropped;
    logic                       r_pop_valid;
    logic [odq_pkg::ID_W-1:0]   r_pop_id;
    logic                       r_pending;
    logic [odq_pkg::COUNT_W-1:0] r_pending_count;

    logic in_range, flag_bit, fire_ok, full, dup, push, pop, commit, rsp_free;
    logic [QUEUE_DEPTH-1:0]     match;
    logic [odq_pkg::ID_W-1:0]   cell_data [QUEUE_DEPTH];

    // No request is taken while reset is held.
    assign i_req.ready = i_rst_n && (r_state == S_IDLE);

    // The response register is free when empty or when its transaction
    // completes in this cycle. The execute step waits for it.
    assign rsp_free = !r_rsp_valid || o_rsp.ready;
    assign commit   = (r_state == S_EXEC) && rsp_free;

    // Fire checks. The id range check uses a widened compare so that an
    // id limit of 64 still works.
    assign in_range = (r_id != '0) &&
                      ({1'b0, r_id} < (odq_pkg::ID_W + 1)'(ID_LIMIT));
    assign fire_ok  = (r_mode == odq_pkg::MODE_FIRE) && in_range &&
                      !(r_use && flag_bit);
    assign full     = (r_count == CW'(QUEUE_DEPTH));
    assign dup      = |match;
    assign push     = fire_ok && !full && !dup;
    assign pop      = (r_mode == odq_pkg::MODE_TAKE) && (r_count != '0);

    odq_flag_map #(
        .ID_LIMIT (ID_LIMIT)
    ) u_flags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (r_id[IDX_W-1:0]),
        .i_set   (commit && fire_ok && r_use),
        .o_flag  (flag_bit)
    );

    // The chain of cells. Cell 0 holds the oldest id; a pop shifts every
    // cell toward the head, and a push loads the cell just past the tail.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        odq_pkg::t_cell_ctl     ctl;
        logic [odq_pkg::ID_W-1:0] nb;

        assign ctl.shift = commit && pop;
        assign ctl.load  = commit && push && (r_count == CW'(g));

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign nb = '0;
        end else begin : g_mid
            assign nb = cell_data[g+1];
        end

        odq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_nb_data   (nb),
            .i_load_data (r_id),
            .i_occupied  (CW'(g) < r_count),
            .i_cmp_id    (r_id),
            .o_data      (cell_data[g]),
            .o_match     (match[g])
        );
    end

    always_comb begin
        n_count = r_count;
        case (r_mode)
            odq_pkg::MODE_FIRE: begin
                if (push) begin
                    n_count = r_count + CW'(1);
                end
            end
            odq_pkg::MODE_TAKE: begin
                if (pop) begin
                    n_count = r_count - CW'(1);
                end
            end
            odq_pkg::MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Sequencer: capture a request, then execute it and load the response.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            // A new response is loaded on commit; otherwise a completed
            // transaction empties the response register.
            if (commit) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_mode  <= i_req.mode;
                        r_id    <= i_req.event_id;
                        r_use   <= i_req.use_once_flags;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (rsp_free) begin
                        r_count         <= n_count;
                        r_accepted      <= fire_ok;
                        r_dropped       <= fire_ok && full;
                        r_pop_valid     <= pop;
                        r_pop_id        <= pop ? cell_data[0] : '0;
                        r_pending       <= (n_count != '0);
                        r_pending_count <= odq_pkg::COUNT_W'(n_count);
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid         = r_rsp_valid;
    assign o_rsp.accepted      = r_accepted;
    assign o_rsp.dropped_full  = r_dropped;
    assign o_rsp.popped_valid  = r_pop_valid;
    assign o_rsp.popped_id     = r_pop_id;
    assign o_rsp.pending       = r_pending;
    assign o_rsp.pending_count = r_pending_count;

`ifndef SYNTHESIS
    // The fill count never passes the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    // The count moves by at most one per step, except when a clear empties it.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count)) ||
                           (r_count == $past(r_count) + CW'(1)) ||
                           (r_count == $past(r_count) - CW'(1)) ||
                           (r_count == '0))
        else $error("queue count jumped");

    // A new response appears only right after an execute step.
    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(r_rsp_valid) |-> $past(r_state == S_EXEC))
        else $error("response without execute step");

    // A response never reports both an accepted fire and a popped id.
    a_rsp_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid |-> !(r_accepted && r_pop_valid))
        else $error("fire and take reported together");
`endif
endmodule
